// ----- rtl/png_unf_pkg.sv -----
package png_unf_pkg;

   // Line buffer and pixel geometry
   localparam int MAX_ROW_BYTES   = 4096;
   localparam int MAX_PIXEL_BYTES = 8;
   localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
   localparam int POS_W           = $clog2(MAX_ROW_BYTES + 1);
   localparam int BPP_IDX_W       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // Register widths
   localparam int BPP_W   = 4;
   localparam int ROWB_W  = 13;
   localparam int ROWS_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_ROW_BYTES       = 2'd1,
      CSR_IMAGE_ROWS      = 2'd2
   } csr_index_type;

   // Row filter codes
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // Predictor operands
   typedef struct packed {
      filter_type filter;
      logic [7:0] left;
      logic [7:0] above;
      logic [7:0] above_left;
   } pred_in_type;

   // Map a filter-type byte to a code; unknown codes reconstruct as None
   function automatic filter_type decode_filter(input logic [7:0] code);
      filter_type f;
      case (code)
         8'd1:    f = FILT_SUB;
         8'd2:    f = FILT_UP;
         8'd3:    f = FILT_AVG;
         8'd4:    f = FILT_PAETH;
         default: f = FILT_NONE;
      endcase
      return f;
   endfunction

endpackage

// ----- rtl/png_scanline_unfilter_top.sv -----
// PNG inverse filter (None/Sub/Up/Average/Paeth), one stream byte per word.
// Each row is a filter-type byte followed by row_bytes filtered bytes; every data
// byte returns one reconstructed byte with row_end and image_end flags, the filter
// byte returns nothing. Input throughput is one byte per clock with no bubbles while
// rsp_ready holds, also across row and image boundaries; rsp valid is registered and
// rises in the cycle after req accept. The previous row lives in a 4096x8 single-write
// RAM whose registered read is issued for the next expected column, so the byte above
// is ready when the data byte arrives. Registers may only change while idle.
module png_scanline_unfilter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_in_byte,
   // result stream
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_pixel_byte,
   output logic                                  rsp_row_end,
   output logic                                  rsp_image_end,
   // configuration
   input  logic                                  csr_we,
   input  logic [png_unf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [png_unf_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int ADDR_W = png_unf_pkg::ADDR_W;
   localparam int POS_W  = png_unf_pkg::POS_W;
   localparam int NPIX   = png_unf_pkg::MAX_PIXEL_BYTES;

   // Configuration registers
   logic [png_unf_pkg::BPP_W-1:0]  bpp_ff;
   logic [png_unf_pkg::ROWB_W-1:0] row_bytes_ff;
   logic [png_unf_pkg::ROWS_W-1:0] image_rows_ff;

   // Row state
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [png_unf_pkg::ROWS_W-1:0]  row_idx_ff, row_idx_in;
   png_unf_pkg::filter_type         filter_ff, filter_in;
   logic [7:0]                      left_hist_ff [NPIX];
   logic [7:0]                      up_hist_ff   [NPIX];
   logic                            clear_hist;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_row_end_ff;
   logic       rsp_image_end_ff;

   // Datapath
   logic                                accept;
   logic                                is_data;
   logic [png_unf_pkg::BPP_W-1:0]       bpp_eff;
   logic [POS_W-1:0]                    rb_eff;
   logic [png_unf_pkg::ROWS_W-1:0]      rows_eff;
   logic [png_unf_pkg::BPP_IDX_W-1:0]   tap;
   logic [POS_W-1:0]                    pos_m1;
   logic [ADDR_W-1:0]                   x;
   logic [ADDR_W-1:0]                   rd_addr;
   logic                                first_row;
   logic                                has_left;
   logic [7:0]                          above_raw;
   logic [7:0]                          above;
   logic [7:0]                          pred;
   logic [7:0]                          val;
   logic                                row_done;
   logic                                img_done;
   logic [png_unf_pkg::ROWS_W:0]        row_idx_p1;
   png_unf_pkg::pred_in_type            pred_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= png_unf_pkg::BPP_W'(4);
         row_bytes_ff  <= png_unf_pkg::ROWB_W'(png_unf_pkg::MAX_ROW_BYTES);
         image_rows_ff <= png_unf_pkg::ROWS_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            png_unf_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[png_unf_pkg::BPP_W-1:0];
            png_unf_pkg::CSR_ROW_BYTES:  row_bytes_ff  <= csr_wdata[png_unf_pkg::ROWB_W-1:0];
            png_unf_pkg::CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata[png_unf_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective register values: zero acts as one, large values saturate
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = png_unf_pkg::BPP_W'(1);
      end else if (bpp_ff > png_unf_pkg::BPP_W'(NPIX)) begin
         bpp_eff = png_unf_pkg::BPP_W'(NPIX);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (row_bytes_ff == '0) begin
         rb_eff = POS_W'(1);
      end else if ({1'b0, row_bytes_ff} > 14'(png_unf_pkg::MAX_ROW_BYTES)) begin
         rb_eff = POS_W'(png_unf_pkg::MAX_ROW_BYTES);
      end else begin
         rb_eff = POS_W'(row_bytes_ff);
      end
      rows_eff = (image_rows_ff == '0) ? png_unf_pkg::ROWS_W'(1) : image_rows_ff;
   end

   // Handshake: the result register frees up when its word is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_data   = (pos_ff != '0);

   // Neighbor selection
   assign pos_m1    = pos_ff - POS_W'(1);
   assign x         = pos_m1[ADDR_W-1:0];
   assign first_row = (row_idx_ff == '0);
   assign has_left  = (pos_ff > POS_W'(bpp_eff));
   assign tap       = png_unf_pkg::BPP_IDX_W'(bpp_eff - png_unf_pkg::BPP_W'(1));
   assign above     = first_row ? 8'd0 : above_raw;

   always_comb begin
      pred_in.filter     = filter_ff;
      pred_in.left       = has_left ? left_hist_ff[tap] : 8'd0;
      pred_in.above      = above;
      pred_in.above_left = (has_left && !first_row) ? up_hist_ff[tap] : 8'd0;
   end

   png_unf_pred u_pred (
      .pred_in  (pred_in),
      .pred_out (pred)
   );

   assign val = req_in_byte + pred;

   // Row and image bookkeeping
   assign row_done   = (pos_ff >= rb_eff);
   assign row_idx_p1 = {1'b0, row_idx_ff} + 17'd1;
   assign img_done   = row_done && (row_idx_p1 >= {1'b0, rows_eff});

   always_comb begin
      pos_in     = pos_ff;
      row_idx_in = row_idx_ff;
      filter_in  = filter_ff;
      clear_hist = 1'b0;
      if (accept) begin
         if (!is_data) begin
            filter_in  = png_unf_pkg::decode_filter(req_in_byte);
            clear_hist = 1'b1;
            pos_in     = POS_W'(1);
         end else if (row_done) begin
            pos_in     = '0;
            row_idx_in = img_done ? '0 : row_idx_p1[png_unf_pkg::ROWS_W-1:0];
         end else begin
            pos_in     = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         row_idx_ff <= '0;
         filter_ff  <= png_unf_pkg::FILT_NONE;
      end else begin
         pos_ff     <= pos_in;
         row_idx_ff <= row_idx_in;
         filter_ff  <= filter_in;
      end
   end

   // Left and above-left byte histories, newest at tap 0
   always_ff @(posedge clock) begin
      if (reset || clear_hist) begin
         for (int i = 0; i < NPIX; i++) begin
            left_hist_ff[i] <= 8'd0;
            up_hist_ff[i]   <= 8'd0;
         end
      end else if (accept && is_data) begin
         left_hist_ff[0] <= val;
         up_hist_ff[0]   <= above;
         for (int i = 1; i < NPIX; i++) begin
            left_hist_ff[i] <= left_hist_ff[i-1];
            up_hist_ff[i]   <= up_hist_ff[i-1];
         end
      end
   end

   // Prefetch the column that the next data byte will need
   always_comb begin
      if (pos_in == '0) begin
         rd_addr = '0;
      end else begin
         rd_addr = ADDR_W'(pos_in - POS_W'(1));
      end
   end

   png_unf_lbuf u_lbuf (
      .clock   (clock),
      .wr_en   (accept && is_data),
      .wr_addr (x),
      .wr_data (val),
      .rd_addr (rd_addr),
      .rd_data (above_raw)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_ready) begin
         rsp_valid_in = accept && is_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_data) begin
         rsp_byte_ff      <= val;
         rsp_row_end_ff   <= row_done;
         rsp_image_end_ff <= img_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_byte_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;

endmodule

// ----- rtl/png_unf_lbuf.sv -----
module png_unf_lbuf (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [png_unf_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic [png_unf_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [png_unf_pkg::MAX_ROW_BYTES];
   logic [7:0] mem_q_ff;
   logic       byp_ff;
   logic [7:0] byp_data_ff;

   // Previous-row storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Same-address write and read: return the new byte
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : mem_q_ff;

endmodule

// ----- rtl/png_unf_pred.sv -----
module png_unf_pred (
   input  png_unf_pkg::pred_in_type pred_in,
   output logic [7:0]               pred_out
);

   logic signed [9:0] da;
   logic signed [9:0] db;
   logic signed [9:0] dc;
   logic [8:0]        pa;
   logic [8:0]        pb;
   logic [8:0]        pc;
   logic [8:0]        avg_sum;
   logic [7:0]        paeth;

   // Paeth distances: |b-c|, |a-c|, |a+b-2c|
   always_comb begin
      da = $signed({2'b00, pred_in.above}) - $signed({2'b00, pred_in.above_left});
      db = $signed({2'b00, pred_in.left})  - $signed({2'b00, pred_in.above_left});
      dc = da + db;
      pa = da[9] ? 9'(-da) : da[8:0];
      pb = db[9] ? 9'(-db) : db[8:0];
      pc = dc[9] ? 9'(-dc) : dc[8:0];
      if ((pa <= pb) && (pa <= pc)) begin
         paeth = pred_in.left;
      end else if (pb <= pc) begin
         paeth = pred_in.above;
      end else begin
         paeth = pred_in.above_left;
      end
   end

   assign avg_sum = {1'b0, pred_in.left} + {1'b0, pred_in.above};

   // Predictor select
   always_comb begin
      case (pred_in.filter)
         png_unf_pkg::FILT_SUB:   pred_out = pred_in.left;
         png_unf_pkg::FILT_UP:    pred_out = pred_in.above;
         png_unf_pkg::FILT_AVG:   pred_out = avg_sum[8:1];
         png_unf_pkg::FILT_PAETH: pred_out = paeth;
         default:                 pred_out = 8'd0;
      endcase
   end

endmodule
